>>> sv/wfr_pkg.sv
// ============================================================================
// wfr_pkg
// Shared types, codes and the CRC-8 byte update for the frame receiver.
// ============================================================================
`default_nettype none

package wfr_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_FRAME_END   = 3'd0;
   localparam logic [2:0] CSR_ESCAPE      = 3'd1;
   localparam logic [2:0] CSR_ESC_END     = 3'd2;
   localparam logic [2:0] CSR_ESC_ESCAPE  = 3'd3;
   localparam logic [2:0] CSR_MAX_LEN     = 3'd4;

   // protocol constants
   localparam logic [7:0] CRC_SEED  = 8'hDE;
   localparam logic [7:0] CRC_TAP   = 8'h18;
   localparam int         ADDR_FLAG = 7;      // bit position of the address flag

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // frame end status
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // parse phase
   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_START = 3'd1,
      PH_ADDR  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRC   = 3'd5
   } phase_type;

   // configuration registers
   typedef struct packed {
      logic [7:0] frame_end_code;
      logic [7:0] escape_code;
      logic [7:0] escaped_end_code;
      logic [7:0] escaped_escape_code;
      logic [7:0] max_data_len;
   } cfg_type;

   // unescaped byte handed from front to back
   typedef struct packed {
      logic       raw_end;   // raw line byte was the frame-end code
      logic       swallowed; // escape byte that only restarts the parser
      logic [7:0] value;     // byte after escape removal
   } token_type;

   // one result beat
   typedef struct packed {
      logic       kind;
      logic       status;
      logic [7:0] byte_count;
      logic [7:0] command;
      logic [6:0] address;
      logic [7:0] data_byte;
   } result_type;

   // reflected CRC-8, one byte, LSB first
   function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
      logic [7:0] crc;
      logic [7:0] b;
      crc = crc_in;
      b   = data_in;
      for (int k = 0; k < 8; k++) begin
         if ((b[0] ^ crc[0]) == 1'b1) begin
            crc = ((crc ^ CRC_TAP) >> 1) | 8'h80;
         end else begin
            crc = crc >> 1;
         end
         b = b >> 1;
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

>>> sv/wfr_front.sv
// ============================================================================
// wfr_front
// Accepts raw line bytes, removes escape pairs and flags raw frame ends.
// ============================================================================
`default_nettype none

module wfr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wfr_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   input  wire logic [7:0]         in_byte,
   output logic                    in_ready,
   output logic                    tok_push,
   output wfr_pkg::token_type      tok_data,
   input  wire logic               q_full
);
   import wfr_pkg::*;

   logic escape_pending_ff;
   logic escape_pending_in;
   logic accept;

   assign in_ready = ~q_full;
   assign accept   = in_valid & in_ready;

   // escape handling: an escape byte is swallowed, the next one is mapped
   always_comb begin
      escape_pending_in  = escape_pending_ff;
      tok_push           = 1'b0;
      tok_data.raw_end   = (in_byte == cfg.frame_end_code);
      tok_data.swallowed = 1'b0;
      tok_data.value     = in_byte;
      if (accept) begin
         if (in_byte == cfg.escape_code && !escape_pending_ff) begin
            escape_pending_in  = 1'b1;
            // an escape byte equal to the frame-end code still restarts the parser
            tok_push           = (in_byte == cfg.frame_end_code);
            tok_data.swallowed = 1'b1;
         end else begin
            tok_push = 1'b1;
            if (escape_pending_ff) begin
               escape_pending_in = 1'b0;
               if (in_byte == cfg.escaped_end_code) begin
                  tok_data.value = cfg.frame_end_code;
               end else if (in_byte == cfg.escaped_escape_code) begin
                  tok_data.value = cfg.escape_code;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
      end else begin
         escape_pending_ff <= escape_pending_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/wfr_queue.sv
// ============================================================================
// wfr_queue
// Two-entry token queue between the front and the back.
// ============================================================================
`default_nettype none

module wfr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire wfr_pkg::token_type push_data,
   input  wire logic               pop,
   output wfr_pkg::token_type      head,
   output logic                    empty,
   output logic                    full
);
   import wfr_pkg::*;

   token_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/wfr_back.sv
// ============================================================================
// wfr_back
// Frame parser: address, command, length, data and CRC check, with the
// result register toward the output channel.
// ============================================================================
`default_nettype none

module wfr_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wfr_pkg::cfg_type   cfg,
   input  wire wfr_pkg::token_type head,
   input  wire logic               q_empty,
   output logic                    pop,
   output logic                    out_valid,
   output wfr_pkg::result_type     out_data,
   input  wire logic               out_ready
);
   import wfr_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] crc_ff, crc_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   phase_type  cur;
   logic [7:0] b;
   logic [7:0] crc_next;
   logic [7:0] cnt_inc;
   logic       slot_free;
   logic       emit;

   assign slot_free = ~valid_ff | out_ready;
   assign pop       = ~q_empty & slot_free;
   assign b         = head.value;
   assign cnt_inc   = cnt_ff + 8'd1;
   assign out_valid = valid_ff;
   assign out_data  = res_ff;

   // parser next state
   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      res_in   = res_ff;
      res_in.kind      = KIND_DATA;
      res_in.status    = STATUS_OK;
      res_in.data_byte = 8'd0;
      cur      = head.raw_end ? PH_WAIT : phase_ff;
      crc_next = crc_byte(crc_ff, b);

      case (cur)
         PH_START: begin
            if (b[ADDR_FLAG]) begin
               addr_in  = b[6:0];
               crc_in   = crc_byte(crc_ff, {1'b0, b[6:0]});
               phase_in = PH_ADDR;
            end else begin
               addr_in  = 7'd0;
               cmd_in   = b;
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end
         end
         PH_ADDR: begin
            cmd_in   = b;
            crc_in   = crc_next;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in = b;
            cnt_in = 8'd0;
            if (b > cfg.max_data_len) begin
               phase_in      = PH_WAIT;
               emit          = 1'b1;
               res_in.kind   = KIND_END;
               res_in.status = STATUS_ERR;
            end else begin
               crc_in   = crc_next;
               phase_in = (b != 8'd0) ? PH_DATA : PH_CRC;
            end
         end
         PH_DATA: begin
            crc_in = crc_next;
            cnt_in = cnt_inc;
            if (cnt_inc == len_ff) begin
               phase_in = PH_CRC;
            end else begin
               phase_in = PH_DATA;
            end
            emit             = 1'b1;
            res_in.data_byte = b;
         end
         PH_CRC: begin
            phase_in      = PH_WAIT;
            emit          = 1'b1;
            res_in.kind   = KIND_END;
            res_in.status = (b == crc_ff) ? STATUS_OK : STATUS_ERR;
         end
         default: begin
            if (b == cfg.frame_end_code) begin
               crc_in   = crc_byte(CRC_SEED, cfg.frame_end_code);
               phase_in = PH_START;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      endcase

      // swallowed escape byte that is also the frame-end code: restart only
      if (head.swallowed) begin
         phase_in = PH_WAIT;
         crc_in   = crc_ff;
      end

      res_in.address    = addr_in;
      res_in.command    = cmd_in;
      res_in.byte_count = len_in;

      // output slot
      if (pop) begin
         valid_in = emit;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // parser state, advanced only when a token is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         crc_ff   <= 8'd0;
         addr_ff  <= 7'd0;
         cmd_ff   <= 8'd0;
         len_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            crc_ff   <= crc_in;
            addr_ff  <= addr_in;
            cmd_ff   <= cmd_in;
            len_ff   <= len_in;
            cnt_ff   <= cnt_in;
         end
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/wake_frame_receiver.sv
// ============================================================================
// wake_frame_receiver
// Receive side of a Wake-style framed serial link with CRC-8 check.
// ============================================================================
// Takes one raw line byte per beat and sustains one byte per clock cycle
// while results are taken. The front stage removes escape pairs in the cycle
// a byte is taken and pushes it into a two-entry queue; the back stage
// parses one queued byte per cycle while its output slot is free (the CRC-8
// byte update is combinational) and places any result in an output register.
// Every data byte leaves as a beat with tuser = 0; the frame end leaves with
// tuser = 1 and the status bit (1 for a length or CRC error). The receiver
// then waits for the next frame-end byte. Registers are written through
// csr_we / csr_index / csr_wdata; the user must write them only while idle,
// which the block itself does not enforce.
// ============================================================================
`default_nettype none

module wake_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   // raw bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] data_byte, [14:8] address,
                                         // [22:15] command, [30:23] byte_count,
                                         // [31] status
   output logic             rsp_tuser    // [0] kind
);
   import wfr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       tok_push;
   token_type  tok_data;
   token_type  q_head;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   result_type res;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_END:  cfg_in.frame_end_code      = csr_wdata;
            CSR_ESCAPE:     cfg_in.escape_code         = csr_wdata;
            CSR_ESC_END:    cfg_in.escaped_end_code    = csr_wdata;
            CSR_ESC_ESCAPE: cfg_in.escaped_escape_code = csr_wdata;
            CSR_MAX_LEN:    cfg_in.max_data_len        = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_end_code      <= 8'd192;
         cfg_ff.escape_code         <= 8'd219;
         cfg_ff.escaped_end_code    <= 8'd220;
         cfg_ff.escaped_escape_code <= 8'd221;
         cfg_ff.max_data_len        <= 8'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_ready (req_tready),
      .tok_push (tok_push),
      .tok_data (tok_data),
      .q_full   (q_full)
   );

   wfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (tok_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   wfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_data  (res),
      .out_ready (rsp_tready)
   );

   // result beat packing
   assign rsp_tdata = {res.status, res.byte_count, res.command, res.address, res.data_byte};
   assign rsp_tuser = res.kind;

endmodule

`default_nettype wire
